// File: src/tcpd_pkg.sv
package tcpd_pkg;

    // token parser phases
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LETTER = 3'd1,
        PH_SPACE  = 3'd2,
        PH_SIGN   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5,
        PH_JUNK   = 3'd6
    } phase_t;

    // value a token writes
    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_S    = 2'd1,
        TGT_T    = 2'd2,
        TGT_M    = 2'd3
    } target_t;

    // configuration register indexes
    localparam logic [1:0] REG_SERVO_MIN   = 2'd0;
    localparam logic [1:0] REG_SERVO_MAX   = 2'd1;
    localparam logic [1:0] REG_MOTOR_LIMIT = 2'd2;

    // characters of the command syntax
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPC   = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;

    // reset values
    localparam logic [15:0] SERVO_MIN_RST   = 16'd1000;
    localparam logic [15:0] SERVO_MAX_RST   = 16'd2000;
    localparam logic [14:0] MOTOR_LIMIT_RST = 15'd1000;
    localparam logic [15:0] SERVO_CENTRE    = 16'd1500;

    // limits handed to the clamp logic
    typedef struct packed {
        logic [15:0] servo_min;
        logic [15:0] servo_max;
        logic [14:0] motor_limit;
    } cfg_t;

endpackage

// File: src/tcpd_clamp.sv
module tcpd_clamp (
    input  tcpd_pkg::cfg_t cfg,
    input  logic [15:0]    steer_raw,
    input  logic [15:0]    sensor_raw,
    input  logic [15:0]    motor_raw,
    output logic [15:0]    steer_clamped,
    output logic [15:0]    sensor_clamped,
    output logic [15:0]    motor_clamped
);
    import tcpd_pkg::*;

    logic [15:0] steer_lo;
    logic [15:0] sensor_lo;
    logic signed [15:0] lim_pos;
    logic signed [15:0] lim_neg;
    logic signed [15:0] motor_s;

    // servo clamp: raise to min first, then cap at max
    always_comb
    begin
        steer_lo       = (steer_raw < cfg.servo_min) ? cfg.servo_min : steer_raw;
        steer_clamped  = (steer_lo > cfg.servo_max) ? cfg.servo_max : steer_lo;
        sensor_lo      = (sensor_raw < cfg.servo_min) ? cfg.servo_min : sensor_raw;
        sensor_clamped = (sensor_lo > cfg.servo_max) ? cfg.servo_max : sensor_lo;
    end

    // signed motor clamp to plus or minus the limit
    always_comb
    begin
        lim_pos = $signed({1'b0, cfg.motor_limit});
        lim_neg = -lim_pos;
        motor_s = $signed(motor_raw);
        if (motor_s > lim_pos)
        begin
            motor_clamped = lim_pos;
        end
        else if (motor_s < lim_neg)
        begin
            motor_clamped = lim_neg;
        end
        else
        begin
            motor_clamped = motor_raw;
        end
    end

endmodule

// File: src/text_command_to_pwm_drive_unit.sv
// Text command receiver for two servos and a DC motor. Bytes of lines such as
// "S:1500,T:1400,M:-300" followed by a newline enter on the s_ stream one per
// transfer; each newline gives one m_ transfer carrying the clamped steering,
// sensor servo and motor drive values and a mask of what the line set. The
// block takes one byte every cycle when not stalled: a byte sits in an input
// register while the parser and clamp logic update the line state, and a
// newline's result goes from there into the output register. Only a newline
// that meets a full output register waits, holding s_tready low until the
// pending result is taken. Limits must be written on the cfg_ channel only
// while the block is idle; the block itself does not enforce this.
module text_command_to_pwm_drive_unit #(
    parameter int LINE_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // fields: rx_byte[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // fields: steering_compare[15:0], sensor_servo_compare[31:16],
    // motor_compare[46:32], motor_forward[47], motor_reverse[48],
    // updated_mask[51:49], zero fill[55:52]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tcpd_pkg::*;

    localparam int POS_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BYTES - 1);

    cfg_t cfg_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t      phase_reg, phase_next;
    target_t     target_reg, target_next;
    logic        neg_reg, neg_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] pend_reg [3];
    logic [15:0] pend_next [3];
    logic [2:0]  pend_valid_reg, pend_valid_next;
    logic        ended_reg, ended_next;
    logic [15:0] steer_reg, steer_next;
    logic [15:0] sensor_reg, sensor_next;
    logic [15:0] motor_reg, motor_next;

    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;

    logic        is_nl;
    logic        go;
    logic        fin_en;
    logic        fin_take;
    logic [15:0] fin_value;
    logic [15:0] pend_f [3];
    logic [2:0]  pend_valid_f;
    logic [15:0] steer_cl, sensor_cl, motor_cl;
    logic        is_digit;
    logic        is_ws;
    logic [15:0] digit_val;
    logic [14:0] motor_mag;

    // handshakes
    assign is_nl     = (in_byte_reg == CH_LF);
    assign go        = in_valid_reg && (!is_nl || !m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || go;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_min   <= SERVO_MIN_RST;
            cfg_reg.servo_max   <= SERVO_MAX_RST;
            cfg_reg.motor_limit <= MOTOR_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SERVO_MIN:   cfg_reg.servo_min   <= cfg_data;
                REG_SERVO_MAX:   cfg_reg.servo_max   <= cfg_data;
                REG_MOTOR_LIMIT: cfg_reg.motor_limit <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // token finish: signed value into the pending slot of its target
    always_comb
    begin
        fin_take  = fin_en && (phase_reg == PH_SPACE || phase_reg == PH_SIGN ||
                    phase_reg == PH_DIGITS || phase_reg == PH_DONE) &&
                    (target_reg != TGT_NONE);
        fin_value = neg_reg ? (16'd0 - acc_reg) : acc_reg;
        pend_f[0] = (fin_take && target_reg == TGT_S) ? fin_value : pend_reg[0];
        pend_f[1] = (fin_take && target_reg == TGT_T) ? fin_value : pend_reg[1];
        pend_f[2] = (fin_take && target_reg == TGT_M) ? fin_value : pend_reg[2];
        pend_valid_f[0] = pend_valid_reg[0] || (fin_take && target_reg == TGT_S);
        pend_valid_f[1] = pend_valid_reg[1] || (fin_take && target_reg == TGT_T);
        pend_valid_f[2] = pend_valid_reg[2] || (fin_take && target_reg == TGT_M);
    end

    tcpd_clamp u_clamp (
        .cfg            (cfg_reg),
        .steer_raw      (pend_f[0]),
        .sensor_raw     (pend_f[1]),
        .motor_raw      (pend_f[2]),
        .steer_clamped  (steer_cl),
        .sensor_clamped (sensor_cl),
        .motor_clamped  (motor_cl)
    );

    // character classes
    assign is_digit  = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign is_ws     = (in_byte_reg == CH_SPC) ||
                       ((in_byte_reg >= CH_HT) && (in_byte_reg <= CH_CR));
    assign digit_val = {8'd0, in_byte_reg - CH_ZERO};

    // line parser and commit
    always_comb
    begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        target_next     = target_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        pend_next[0]    = pend_reg[0];
        pend_next[1]    = pend_reg[1];
        pend_next[2]    = pend_reg[2];
        pend_valid_next = pend_valid_reg;
        ended_next      = ended_reg;
        steer_next      = steer_reg;
        sensor_next     = sensor_reg;
        motor_next      = motor_reg;
        fin_en          = 1'b0;
        if (is_nl)
        begin
            fin_en = !ended_reg;
        end
        else if (!ended_reg)
        begin
            fin_en = (in_byte_reg == CH_NUL) || (in_byte_reg == CH_COMMA);
        end

        if (go)
        begin
            if (is_nl)
            begin
                // commit the line, then clear it
                if (pend_valid_f[0])
                begin
                    steer_next = steer_cl;
                end
                if (pend_valid_f[1])
                begin
                    sensor_next = sensor_cl;
                end
                if (pend_valid_f[2])
                begin
                    motor_next = motor_cl;
                end
            end
            else
            begin
                if (fin_en)
                begin
                    pend_next[0]    = pend_f[0];
                    pend_next[1]    = pend_f[1];
                    pend_next[2]    = pend_f[2];
                    pend_valid_next = pend_valid_f;
                    phase_next      = PH_START;
                    target_next     = TGT_NONE;
                    neg_next        = 1'b0;
                    acc_next        = 16'd0;
                    ended_next      = (in_byte_reg == CH_NUL);
                end
                else if (!ended_reg)
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            phase_next = PH_LETTER;
                            if (in_byte_reg == CH_S)
                            begin
                                target_next = TGT_S;
                            end
                            else if (in_byte_reg == CH_T)
                            begin
                                target_next = TGT_T;
                            end
                            else if (in_byte_reg == CH_M)
                            begin
                                target_next = TGT_M;
                            end
                            else
                            begin
                                phase_next = PH_JUNK;
                            end
                        end
                        PH_LETTER:
                        begin
                            if (in_byte_reg == CH_COLON)
                            begin
                                phase_next = PH_SPACE;
                            end
                            else
                            begin
                                target_next = TGT_NONE;
                                phase_next  = PH_JUNK;
                            end
                        end
                        PH_SPACE:
                        begin
                            if (is_ws)
                            begin
                                phase_next = PH_SPACE;
                            end
                            else if (in_byte_reg == CH_PLUS || in_byte_reg == CH_MINUS)
                            begin
                                neg_next   = (in_byte_reg == CH_MINUS);
                                phase_next = PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                acc_next   = digit_val;
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_SIGN, PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                // times ten as two shifts, modulo 2^16
                                acc_next   = (acc_reg << 3) + (acc_reg << 1) + digit_val;
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                pos_next = pos_reg + 1'b1;
            end

            // newline or line overflow clears the line
            if (is_nl || pos_reg == POS_LAST)
            begin
                pos_next        = '0;
                phase_next      = PH_START;
                target_next     = TGT_NONE;
                neg_next        = 1'b0;
                acc_next        = 16'd0;
                pend_next[0]    = 16'd0;
                pend_next[1]    = 16'd0;
                pend_next[2]    = 16'd0;
                pend_valid_next = 3'd0;
                ended_next      = 1'b0;
            end
        end
    end

    // result word
    always_comb
    begin
        motor_mag   = motor_next[15] ? 15'(16'd0 - motor_next) : motor_next[14:0];
        m_data_next = {4'd0, pend_valid_f,
                       motor_next[15],
                       (!motor_next[15] && motor_next != 16'd0),
                       motor_mag, sensor_next, steer_next};
        if (go && is_nl)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_START;
            target_reg     <= TGT_NONE;
            neg_reg        <= 1'b0;
            acc_reg        <= 16'd0;
            pend_reg[0]    <= 16'd0;
            pend_reg[1]    <= 16'd0;
            pend_reg[2]    <= 16'd0;
            pend_valid_reg <= 3'd0;
            ended_reg      <= 1'b0;
            steer_reg      <= SERVO_CENTRE;
            sensor_reg     <= SERVO_CENTRE;
            motor_reg      <= 16'd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            target_reg     <= target_next;
            neg_reg        <= neg_next;
            acc_reg        <= acc_next;
            pend_reg[0]    <= pend_next[0];
            pend_reg[1]    <= pend_next[1];
            pend_reg[2]    <= pend_next[2];
            pend_valid_reg <= pend_valid_next;
            ended_reg      <= ended_next;
            steer_reg      <= steer_next;
            sensor_reg     <= sensor_next;
            motor_reg      <= motor_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (go && is_nl)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("line position beyond line length");

    a_dir_pins: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[47] && m_tdata[48]))
        else $error("both motor direction pins set");

    a_nl_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && is_nl && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while newline result blocked");

    a_ended_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ended_reg && go && !is_nl && pos_reg != POS_LAST) |=> $stable(pend_valid_reg))
        else $error("pending values changed after zero byte");

endmodule

// File: bench/text_command_to_pwm_drive_unit_test.sv
`timescale 1ns / 1ps

import tcpd_pkg::*;

// one m_tdata word, lowest field last
typedef struct packed {
    logic [3:0]  fill;
    logic [2:0]  updated_mask;
    logic        motor_reverse;
    logic        motor_forward;
    logic [14:0] motor_compare;
    logic [15:0] sensor_servo_compare;
    logic [15:0] steering_compare;
} drive_word_t;

// line parser and drive state, predicting one word per newline
class drive_scoreboard;
    cfg_t           limits;
    int unsigned    line_len;
    int unsigned    line_pos;
    phase_t         phase;
    target_t        target;
    bit             negative;
    logic [15:0]    accum;
    logic [15:0]    pending [3];
    logic [2:0]     pending_set;
    bit             content_ended;
    logic [15:0]    steering;
    logic [15:0]    sensor_servo;
    logic [15:0]    motor_speed;
    drive_word_t    expected [$];
    int             errors;

    function new(int unsigned len);
        line_len = len;
        limits.servo_min = SERVO_MIN_RST;
        limits.servo_max = SERVO_MAX_RST;
        limits.motor_limit = MOTOR_LIMIT_RST;
        steering = SERVO_CENTRE;
        sensor_servo = SERVO_CENTRE;
        motor_speed = '0;
        errors = 0;
        clear_line();
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] data);
        case (index)
            REG_SERVO_MIN:   limits.servo_min = data;
            REG_SERVO_MAX:   limits.servo_max = data;
            REG_MOTOR_LIMIT: limits.motor_limit = data[14:0];
            default: ;
        endcase
    endfunction

    function int pending_lines();
        return expected.size();
    endfunction

    function void clear_token();
        phase = PH_START;
        target = TGT_NONE;
        negative = 1'b0;
        accum = '0;
    endfunction

    function void clear_line();
        clear_token();
        foreach (pending[i])
            pending[i] = '0;
        pending_set = '0;
        content_ended = 1'b0;
        line_pos = 0;
    endfunction

    // a token with a target and a colon leaves its number pending
    function void end_token();
        logic [15:0] v;
        if (phase >= PH_SPACE && phase <= PH_DONE && target != TGT_NONE)
        begin
            v = negative ? (16'd0 - accum) : accum;
            pending[int'(target) - 1] = v;
            pending_set[int'(target) - 1] = 1'b1;
        end
        clear_token();
    endfunction

    function void parse_char(logic [7:0] c);
        bit digit;
        bit blank;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        blank = (c == CH_SPC) || (c >= CH_HT && c <= CH_CR);
        case (phase)
            PH_START:
            begin
                phase = PH_LETTER;
                if (c == CH_S)
                    target = TGT_S;
                else if (c == CH_T)
                    target = TGT_T;
                else if (c == CH_M)
                    target = TGT_M;
                else
                    phase = PH_JUNK;
            end
            PH_LETTER:
            begin
                if (c == CH_COLON)
                    phase = PH_SPACE;
                else
                begin
                    target = TGT_NONE;
                    phase = PH_JUNK;
                end
            end
            PH_SPACE:
            begin
                if (blank)
                    ;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative = (c == CH_MINUS);
                    phase = PH_SIGN;
                end
                else if (digit)
                begin
                    accum = 16'(c - CH_ZERO);
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_DONE;
            end
            PH_SIGN, PH_DIGITS:
            begin
                if (digit)
                begin
                    accum = 16'(accum * 16'd10 + 16'(c - CH_ZERO));
                    phase = PH_DIGITS;
                end
                else
                    phase = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    function logic [15:0] clamp_servo(logic [15:0] v);
        if (v < limits.servo_min)
            v = limits.servo_min;
        if (v > limits.servo_max)
            v = limits.servo_max;
        return v;
    endfunction

    // one accepted byte; a newline commits the line and queues a word
    function void note_byte(logic [7:0] c);
        drive_word_t w;
        int s;
        int lim;
        if (c == CH_LF)
        begin
            if (!content_ended)
                end_token();
            if (pending_set[0])
                steering = clamp_servo(pending[0]);
            if (pending_set[1])
                sensor_servo = clamp_servo(pending[1]);
            if (pending_set[2])
            begin
                s = int'($signed(pending[2]));
                lim = int'(limits.motor_limit);
                if (s > lim)
                    s = lim;
                if (s < -lim)
                    s = -lim;
                motor_speed = 16'(s);
            end
            w.updated_mask = pending_set;
            clear_line();
            s = int'($signed(motor_speed));
            w.fill = '0;
            w.steering_compare = steering;
            w.sensor_servo_compare = sensor_servo;
            w.motor_compare = 15'(s < 0 ? -s : s);
            w.motor_forward = (s > 0);
            w.motor_reverse = (s < 0);
            expected.push_back(w);
        end
        else
        begin
            if (!content_ended)
            begin
                if (c == CH_NUL)
                begin
                    end_token();
                    content_ended = 1'b1;
                end
                else if (c == CH_COMMA)
                    end_token();
                else
                    parse_char(c);
            end
            line_pos++;
            // line overflow drops everything collected so far
            if (line_pos >= line_len)
                clear_line();
        end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [55:0] data);
        drive_word_t got;
        drive_word_t want;
        got = data;
        if (expected.size() == 0)
        begin
            $error("result %h with no line waiting", data);
            errors++;
            return;
        end
        want = expected.pop_front();
        compare_field("steering_compare", want.steering_compare, got.steering_compare);
        compare_field("sensor_servo_compare", want.sensor_servo_compare,
                      got.sensor_servo_compare);
        compare_field("motor_compare", want.motor_compare, got.motor_compare);
        compare_field("motor_forward", want.motor_forward, got.motor_forward);
        compare_field("motor_reverse", want.motor_reverse, got.motor_reverse);
        compare_field("updated_mask", want.updated_mask, got.updated_mask);
        compare_field("zero fill", want.fill, got.fill);
    endfunction
endclass

module text_command_to_pwm_drive_unit_test;

    localparam int LINE_LEN    = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_BYTES = 225;

    typedef logic [7:0] char_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    drive_scoreboard board;
    char_t           line_buf [$];
    int unsigned     cycles = 0;
    int unsigned     burst_left = 0;
    int unsigned     ready_mode = 0;
    int unsigned     mode_left = 0;

    text_command_to_pwm_drive_unit #(
        .LINE_BYTES(LINE_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // watch every transfer on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // receiver back-pressure, switching between stall patterns
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        case (ready_mode)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            2: m_tready = $urandom_range(0, 1);
            default: m_tready = ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic char_t junk_char();
        char_t c;
        c = char_t'($urandom_range(8'h21, 8'h7E));
        if (c == CH_COMMA)
            c = CH_PLUS;
        return c;
    endfunction

    function automatic char_t blank_char();
        char_t c;
        c = char_t'($urandom_range(CH_HT, CH_CR));
        if (c == CH_LF)
            c = CH_SPC;
        return c;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(char_t'(s[i]));
    endfunction

    // one token, mostly well formed, with random spacing, sign and number
    function automatic void add_token();
        int unsigned value;
        case ($urandom_range(0, 11))
            0, 1, 2: line_buf.push_back(CH_S);
            3, 4, 5: line_buf.push_back(CH_T);
            6, 7, 8: line_buf.push_back(CH_M);
            default: line_buf.push_back(junk_char());
        endcase
        if ($urandom_range(0, 11) == 0)
            line_buf.push_back(junk_char());
        else
            line_buf.push_back(CH_COLON);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                line_buf.push_back(blank_char());
        case ($urandom_range(0, 5))
            0: line_buf.push_back(CH_PLUS);
            1, 2: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: value = 0;
            1: value = $urandom;
            2, 3, 4: value = $urandom_range(0, 3000);
            5, 6: value = $urandom_range(0, 65535);
            7: value = $urandom_range(0, 9);
            default: value = $urandom_range(500, 2500);
        endcase
        // a bare prefix now and then
        if (value != 0 || $urandom_range(0, 1) == 0)
            add_text($sformatf("%0d", value));
        // trailing junk after the number
        if ($urandom_range(0, 5) == 0)
        begin
            line_buf.push_back(junk_char());
            if ($urandom_range(0, 1) == 0)
                add_text($sformatf("%0d", $urandom_range(0, 999)));
        end
    endfunction

    function automatic void add_tokens(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i > 0)
                line_buf.push_back(CH_COMMA);
            // empty tokens
            if ($urandom_range(0, 7) == 0)
                line_buf.push_back(CH_COMMA);
            add_token();
        end
    endfunction

    // one random line ending in a newline
    function automatic void build_line();
        int unsigned kind;
        int unsigned target_len;
        line_buf.delete();
        kind = $urandom_range(0, 19);
        if (kind < 13)
            add_tokens($urandom_range(1, 4));
        else if (kind < 15)
        begin
            // zero byte ends the content; later tokens are ignored
            add_tokens($urandom_range(1, 3));
            line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
            line_buf.push_back(CH_COMMA);
            add_token();
        end
        else if (kind < 17)
        begin
            repeat ($urandom_range(1, 24))
                line_buf.push_back(char_t'($urandom_range(0, 255)));
        end
        else if (kind < 18)
        begin
            // runs past the line buffer and wraps
            target_len = LINE_LEN + $urandom_range(0, 70);
            add_token();
            while (line_buf.size() < target_len)
            begin
                line_buf.push_back(CH_COMMA);
                add_token();
            end
            line_buf.push_back(CH_COMMA);
            add_tokens($urandom_range(1, 2));
        end
        else
        begin
            repeat (3)
            begin
                add_token();
                line_buf.push_back(char_t'($urandom_range(1, 255)));
            end
        end
        line_buf.push_back(CH_LF);
    endfunction

    // sender in bursts with random gaps
    task automatic send_line();
        int unsigned gap;
        foreach (line_buf[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    s_tdata = char_t'($urandom);
                end
            end
            burst_left--;
            @(negedge clk);
            s_tvalid = 1'b1;
            s_tdata = line_buf[i];
            do
                @(posedge clk);
            while (!s_tready);
        end
    endtask

    // stop sending until every pending line has been answered
    task automatic drain_lines();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending_lines() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int unsigned phase_bytes;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] lim;

        board = new(LINE_LEN);
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SERVO_MIN;
        cfg_data = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty line
        line_buf = {CH_LF};
        send_line();
        // bare prefix, clamped up to the minimum
        line_buf.delete();
        add_text("S:");
        line_buf.push_back(CH_LF);
        send_line();
        // junk after digits, empty token, whitespace, repeated target
        line_buf.delete();
        add_text("M:-7a,,M:");
        line_buf.push_back(CH_HT);
        add_text("9");
        line_buf.push_back(CH_LF);
        send_line();
        // zero byte cuts off the rest of the line
        line_buf.delete();
        add_text("T:3");
        line_buf.push_back(CH_NUL);
        add_text("S:5");
        line_buf.push_back(CH_LF);
        send_line();
        // top byte value opens a junk token
        line_buf = {8'hFF};
        add_text("S:1");
        line_buf.push_back(CH_LF);
        send_line();

        // random lines under several limit settings
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                drain_lines();
                case (p)
                    1:
                    begin
                        lo = 16'd0;
                        hi = 16'hFFFF;
                        lim = 16'h7FFF;
                    end
                    2:
                    begin
                        lo = 16'd3000;
                        hi = 16'd1200;
                        lim = 16'd0;
                    end
                    3:
                    begin
                        lo = 16'd1500;
                        hi = 16'd1500;
                        lim = 16'd1;
                    end
                    4:
                    begin
                        lo = $urandom_range(500, 1500);
                        hi = $urandom_range(1500, 2500);
                        lim = $urandom_range(0, 32767);
                    end
                    default:
                    begin
                        lo = $urandom_range(0, 65535);
                        hi = $urandom_range(0, 65535);
                        lim = $urandom_range(0, 32767);
                    end
                endcase
                write_reg(REG_SERVO_MIN, lo);
                write_reg(REG_SERVO_MAX, hi);
                write_reg(REG_MOTOR_LIMIT, lim);
            end
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_line();
                if ($urandom_range(0, 24) == 0)
                    drain_lines();
                send_line();
                phase_bytes += line_buf.size();
            end
        end

        drain_lines();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
